// ----- sv/hsdf_pkg.sv -----
// Shared types for the host sequence duplicate filter: status codes, op codes,
// control states, the request token that walks the cell chain and the insert
// command. No dependencies.
`default_nettype none

package hsdf_pkg;

   localparam int HOST_W = 32;
   localparam int SEQ_W  = 8;

   typedef enum logic {
      OP_RX = 1'b0,   // received packet check
      OP_TX = 1'b1    // allocate transmit sequence
   } op_type;

   typedef enum logic [2:0] {
      ST_KNOWN = 3'd0,
      ST_NEW   = 3'd1,
      ST_DUP   = 3'd2,
      ST_NAK   = 3'd3,
      ST_MISS  = 3'd4
   } status_type;

   // Top-level control: one request in flight.
   typedef enum logic {
      CTL_IDLE,
      CTL_BUSY
   } ctl_state_type;

   // Request in flight along the chain, with the answer built up so far.
   typedef struct packed {
      logic              active;
      op_type            op;
      logic [HOST_W-1:0] host_id;
      logic [SEQ_W-1:0]  seq;
      logic              found;
      status_type        status;
      logic              accept;
      logic              resynced;
      logic [SEQ_W-1:0]  tx_order;
   } token_type;

   // Overwrite of one entry by a new host.
   typedef struct packed {
      logic              en;
      logic [HOST_W-1:0] host_id;
      logic [SEQ_W-1:0]  seq;
   } ins_type;

endpackage

`default_nettype wire

// ----- sv/hsdf_cell.sv -----
// One table entry of the duplicate filter: host id, rx and tx sequence, plus
// one token stage of the search chain. Depends on hsdf_pkg.
`default_nettype none

module hsdf_cell
   import hsdf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  token_type upstream_tok,
   input  ins_type   ins,
   output token_type downstream_tok
);

   logic [HOST_W-1:0] host_ff, host_in;
   logic [SEQ_W-1:0]  rx_ff, rx_in;
   logic [SEQ_W-1:0]  tx_ff, tx_in;
   logic [SEQ_W-1:0]  rx_plus;
   token_type         tok_ff, tok_in;
   logic              hit;

   assign rx_plus = rx_ff + SEQ_W'(1);
   assign hit     = upstream_tok.active && !upstream_tok.found &&
                    (host_ff == upstream_tok.host_id);

   always_comb begin
      host_in = host_ff;
      rx_in   = rx_ff;
      tx_in   = tx_ff;
      tok_in  = upstream_tok;
      if (ins.en) begin
         host_in = ins.host_id;
         rx_in   = ins.seq;
         tx_in   = ins.seq;
      end else if (hit) begin
         tok_in.found = 1'b1;
         unique case (upstream_tok.op)
            OP_RX: begin
               if (rx_ff == upstream_tok.seq) begin
                  tok_in.status = ST_DUP;
               end else begin
                  tok_in.status = ST_KNOWN;
                  tok_in.accept = 1'b1;
                  rx_in         = upstream_tok.seq;
                  // gap in the order: resync tx to the peer
                  if (rx_plus != upstream_tok.seq) begin
                     tx_in           = upstream_tok.seq;
                     tok_in.resynced = 1'b1;
                  end
               end
            end
            OP_TX: begin
               tok_in.status   = ST_KNOWN;
               tok_in.tx_order = tx_ff;
               tx_in           = tx_ff + SEQ_W'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff       <= '0;
         rx_ff         <= '0;
         tx_ff         <= '0;
         tok_ff.active <= 1'b0;
      end else begin
         host_ff <= host_in;
         rx_ff   <= rx_in;
         tx_ff   <= tx_in;
         tok_ff  <= tok_in;
      end
   end

   assign downstream_tok = tok_ff;

endmodule

`default_nettype wire

// ----- sv/host_sequence_duplicate_filter.sv -----
// Host sequence duplicate filter: one request in flight, so a new req beat is
// taken only once the previous result is loaded into the rsp register
// (req_tready rises again as that result is loaded). An accepted beat passes
// the inject stage, then the token walks the chain of TABLE_DEPTH entry cells,
// one cell per cycle, then the finish stage and the rsp register.
// Synchronous reset clears every entry and the insert slot to 0; the block
// takes a beat in the first cycle after reset.
`default_nettype none

module host_sequence_duplicate_filter
   import hsdf_pkg::*;
#(
   parameter int TABLE_DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // host_id[31:0], seq_num[39:32]
   input  logic [1:0]  req_tuser,   // op[0], is_nak[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[2:0], accept[3], resynced[4],
                                    // tx_order[12:5], zero[15:13]
);

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   ctl_state_type state_ff, state_in;

   token_type   inject_ff, inject_in;
   token_type   tok [TABLE_DEPTH+1];
   token_type   fin_ff;
   logic        fin_go;
   logic        do_insert;
   logic [SLOT_W-1:0] insert_slot_ff, insert_slot_in;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        req_hs;
   logic [TABLE_DEPTH+1:0] act_vec;
   status_type  fin_status;
   logic        fin_accept;

   assign req_hs = req_tvalid && req_tready;

   // ---------------- control: one request in flight ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: if (req_hs) begin
            state_in = CTL_BUSY;
         end
         CTL_BUSY: if (fin_go) begin
            state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == CTL_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- inject stage ----------------
   // NAK beats on rx are resolved here and ride the chain untouched.
   always_comb begin
      inject_in.active   = req_hs;
      inject_in.op       = op_type'(req_tuser[0]);
      inject_in.host_id  = req_tdata[31:0];
      inject_in.seq      = req_tdata[39:32];
      inject_in.found    = req_tuser[1] && (op_type'(req_tuser[0]) == OP_RX);
      inject_in.status   = inject_in.found ? ST_NAK : ST_KNOWN;
      inject_in.accept   = 1'b0;
      inject_in.resynced = 1'b0;
      inject_in.tx_order = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inject_ff.active <= 1'b0;
      end else begin
         inject_ff <= inject_in;
      end
   end

   assign tok[0] = inject_ff;

   // ---------------- chain of entry cells ----------------
   // Lowest cell sees the token first, so the lowest matching entry wins.
   assign do_insert = fin_go && !fin_ff.found && (fin_ff.op == OP_RX);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ins_type ins;
      assign ins.en      = do_insert && (insert_slot_ff == SLOT_W'(i));
      assign ins.host_id = fin_ff.host_id;
      assign ins.seq     = fin_ff.seq;

      hsdf_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .upstream_tok   (tok[i]),
         .ins            (ins),
         .downstream_tok (tok[i+1])
      );

      assign act_vec[i+1] = tok[i+1].active;
   end

   assign act_vec[0]             = inject_ff.active;
   assign act_vec[TABLE_DEPTH+1] = fin_ff.active;

   // ---------------- finish stage ----------------
   // Holds the token until the rsp register is free; a miss on rx enters a
   // new host at the round-robin slot at that moment.
   assign fin_go = fin_ff.active && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.active <= 1'b0;
      end else if (tok[TABLE_DEPTH].active) begin
         fin_ff <= tok[TABLE_DEPTH];
      end else if (fin_go) begin
         fin_ff.active <= 1'b0;
      end
   end

   always_comb begin
      insert_slot_in = insert_slot_ff;
      if (do_insert) begin
         if (insert_slot_ff == SLOT_W'(TABLE_DEPTH - 1)) begin
            insert_slot_in = '0;
         end else begin
            insert_slot_in = insert_slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         insert_slot_ff <= '0;
      end else begin
         insert_slot_ff <= insert_slot_in;
      end
   end

   always_comb begin
      fin_status = fin_ff.status;
      fin_accept = fin_ff.accept;
      if (!fin_ff.found) begin
         unique case (fin_ff.op)
            OP_RX: begin
               fin_status = ST_NEW;
               fin_accept = 1'b1;
            end
            OP_TX: fin_status = ST_MISS;
            default: ;
         endcase
      end
      rsp_data_in = {3'b000, fin_ff.tx_order, fin_ff.resynced, fin_accept, fin_status};
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // at most one token anywhere between inject and finish
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one request in flight");

   // an idle controller has an empty chain
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_IDLE) |-> (act_vec == '0))
      else $error("token in chain while idle");

   // the insert slot moves only with a new-host result
   a_slot_move: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (insert_slot_ff != $past(insert_slot_ff)) |->
         rsp_tvalid && (rsp_tdata[2:0] == ST_NEW))
      else $error("insert slot moved without a new host");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for host_sequence_duplicate_filter: directed and random request beats,
// with results checked against a local model of the host table.
// Depends on hsdf_pkg and the host_sequence_duplicate_filter RTL.
`timescale 1ns / 1ps

module tb
   import hsdf_pkg::*;
();

   localparam int TABLE_DEPTH = 8;
   localparam int POOL_SIZE   = 12;   // more hosts than slots, so entries get evicted

   // One result beat as the block should present it.
   typedef struct {
      status_type       status;
      logic             accept;
      logic             resynced;
      logic [SEQ_W-1:0] tx_order;
   } filter_verdict_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // host_id[31:0], seq_num[39:32]
   logic [1:0]  req_tuser  = '0;   // op[0], is_nak[1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // status[2:0], accept[3], resynced[4], tx_order[12:5]

   // Local copy of the host table, kept in step with every accepted request beat.
   logic [HOST_W-1:0] host_tab [TABLE_DEPTH];
   logic [SEQ_W-1:0]  rx_tab   [TABLE_DEPTH];
   logic [SEQ_W-1:0]  tx_tab   [TABLE_DEPTH];
   int                next_slot;

   filter_verdict_type verdict_q[$];   // verdicts still owed by the block, oldest first
   int                 error_count = 0;

   // Idling on or off for each side; changed per test.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   // Host pool used to shape random traffic into plausible per-host sequences.
   logic [HOST_W-1:0] pool_id  [POOL_SIZE];
   logic [SEQ_W-1:0]  pool_seq [POOL_SIZE];

   always #4 clock = ~clock;

   host_sequence_duplicate_filter #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Works out the verdict for one request and updates the local table.
   // Lowest matching entry wins; cleared entries all match host 0.
   function automatic filter_verdict_type judge_packet(input op_type op,
                                                       input logic [HOST_W-1:0] id,
                                                       input logic [SEQ_W-1:0] seq,
                                                       input logic nak);
      filter_verdict_type v;
      int                 hit;
      logic [SEQ_W-1:0]   next_rx;
      v.status   = ST_KNOWN;
      v.accept   = 1'b0;
      v.resynced = 1'b0;
      v.tx_order = '0;
      hit = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--)
         if (host_tab[i] == id) hit = i;
      if (op == OP_RX) begin
         if (nak) begin
            v.status = ST_NAK;
         end else if (hit >= 0) begin
            if (rx_tab[hit] == seq) begin
               v.status = ST_DUP;
            end else begin
               next_rx = rx_tab[hit] + 8'd1;   // 8-bit wrap
               if (next_rx != seq) begin
                  tx_tab[hit] = seq;
                  v.resynced  = 1'b1;
               end
               rx_tab[hit] = seq;
               v.accept    = 1'b1;
            end
         end else begin
            // unknown host takes the round-robin slot
            host_tab[next_slot] = id;
            rx_tab[next_slot]   = seq;
            tx_tab[next_slot]   = seq;
            next_slot           = (next_slot + 1) % TABLE_DEPTH;
            v.status            = ST_NEW;
            v.accept            = 1'b1;
         end
      end else begin
         if (hit >= 0) begin
            v.tx_order  = tx_tab[hit];
            tx_tab[hit] = tx_tab[hit] + 8'd1;
         end else begin
            v.status = ST_MISS;
         end
      end
      return v;
   endfunction

   // Sends one request beat. Called in the time step of the previous acceptance
   // (or of reset release), so a zero gap keeps tvalid high without a dip.
   task automatic send_request(input op_type op, input logic [HOST_W-1:0] id,
                               input logic [SEQ_W-1:0] seq, input logic nak);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {seq, id};
      req_tuser  <= {nak, op};
      do @(posedge clock); while (req_tready !== 1'b1);
      verdict_q.push_back(judge_packet(op, id, seq, nak));
   endtask

   // Sender holds off until every owed result has been taken.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   // Result side: random stall before each beat, then compare with the oldest verdict.
   initial begin : rsp_checker
      int                 stall;
      filter_verdict_type want;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (verdict_q.size() == 0) begin
            report_mismatch("verdicts outstanding at result beat", 0, 1);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[2:0] !== want.status)
               report_mismatch("status", rsp_tdata[2:0], want.status);
            if (rsp_tdata[3] !== want.accept)
               report_mismatch("accept", rsp_tdata[3], want.accept);
            if (rsp_tdata[4] !== want.resynced)
               report_mismatch("resynced", rsp_tdata[4], want.resynced);
            if (rsp_tdata[12:5] !== want.tx_order)
               report_mismatch("tx_order", rsp_tdata[12:5], want.tx_order);
         end
      end
   end

   // Cleared table: host 0 already matches every entry with rx = tx = 0.
   task automatic test_cleared_table();
      send_request(OP_RX, 32'h0, 8'd0, 1'b0);          // duplicate of the cleared entry
      send_request(OP_TX, 32'h0, 8'd0, 1'b0);          // known host, hands out 0
      send_request(OP_TX, 32'h1234_5678, 8'd0, 1'b0);  // host not found
      send_request(OP_RX, 32'h0, 8'd1, 1'b0);          // in order, no resync
      send_request(OP_RX, 32'h0, 8'd5, 1'b0);          // gap, tx resynced to 5
      send_request(OP_TX, 32'h0, 8'd0, 1'b0);          // hands out 5
   endtask

   // Field extremes, sequence wrap at 255, NAK and ignored fields on transmit.
   task automatic test_field_extremes();
      send_request(OP_RX, 32'hFFFF_FFFF, 8'd255, 1'b0);  // new host
      send_request(OP_RX, 32'hFFFF_FFFF, 8'd0, 1'b0);    // 255 -> 0 is in order
      send_request(OP_TX, 32'hFFFF_FFFF, 8'd0, 1'b0);    // tx 255
      send_request(OP_TX, 32'hFFFF_FFFF, 8'd255, 1'b1);  // tx wraps to 0, seq/nak ignored
      send_request(OP_RX, 32'hFFFF_FFFF, 8'd255, 1'b1);  // NAK, entry left as it is
      send_request(OP_RX, 32'hFFFF_FFFF, 8'd0, 1'b0);    // duplicate
      send_request(OP_RX, 32'hFFFF_FFFF, 8'd200, 1'b0);  // gap, resync
   endtask

   // Nine new hosts wrap the insert slot and push out the oldest newcomer.
   task automatic test_slot_eviction();
      for (int i = 0; i < TABLE_DEPTH + 1; i++)
         send_request(OP_RX, 32'hA5A5_0000 + i, 8'(i * 37), 1'b0);
      send_request(OP_TX, 32'hA5A5_0000, 8'd0, 1'b0);    // evicted by now
   endtask

   // One random beat, mostly well-formed per-host traffic with some noise.
   task automatic send_random_request();
      int               pick;
      int               idx;
      logic [SEQ_W-1:0] seq;
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 10) begin
         // noise: any field value at all
         send_request(op_type'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) != 0) ? pool_id[idx] : $urandom(),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 24) begin
         send_request(OP_TX, pool_id[idx], 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      end else if (pick < 31) begin
         send_request(OP_RX, pool_id[idx], 8'($urandom_range(0, 255)), 1'b1);
      end else begin
         if (pick < 41)      seq = pool_seq[idx];                  // repeat
         else if (pick < 50) seq = 8'($urandom_range(0, 255));     // gap
         else                seq = pool_seq[idx] + 8'd1;           // in order
         pool_seq[idx] = seq;
         send_request(OP_RX, pool_id[idx], seq, 1'b0);
      end
   endtask

   task automatic test_random_traffic(input int count);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (count) send_random_request();
   endtask

   // No idling on either side: each beat is offered as soon as the last is taken.
   task automatic test_back_to_back(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (count) send_random_request();
   endtask

   // Bursts separated by full drains, the sender waiting on the last result.
   task automatic test_drain_and_resume(input int bursts, input int per_burst);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (bursts) begin
         repeat (per_burst) send_random_request();
         wait_for_results();
         req_idle_on = ~req_idle_on;
      end
   endtask

   initial begin : main
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         host_tab[i] = '0;
         rx_tab[i]   = '0;
         tx_tab[i]   = '0;
      end
      next_slot = 0;
      pool_id[0] = 32'h0;
      pool_id[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) pool_id[i] = $urandom();
      for (int i = 0; i < POOL_SIZE; i++) pool_seq[i] = 8'($urandom_range(0, 255));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_cleared_table();
      test_field_extremes();
      test_slot_eviction();
      test_random_traffic(300);
      test_back_to_back(150);
      test_drain_and_resume(7, 25);

      // Drain, then allow the chain latency for any stray beat to show.
      wait_for_results();
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch("results outstanding at end", verdict_q.size(), 0);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
sv/hsdf_pkg.sv
sv/hsdf_cell.sv
sv/host_sequence_duplicate_filter.sv
test/tb.sv
